// ===== hdl/shbs_pkg.sv =====
`default_nettype none
package shbs_pkg;

	localparam int RoundCount = 64;
	localparam int LenOffset = 56;
	localparam int FifoDepthDefault = 4;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// classified beat from the front end
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       is_end;
	} beat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ===== hdl/shbs_front.sv =====
`default_nettype none
module shbs_front #(
	parameter int Depth = shbs_pkg::FifoDepthDefault
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      data_byte,
	input  wire logic            byte_valid,
	input  wire logic            message_end,
	output logic                 full,
	output shbs_pkg::beat_t      q_beat,
	output logic                 q_valid,
	input  wire logic            q_take
);
	import shbs_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	beat_t          mem_q [Depth];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;
	logic           push_ok, pop_ok, useful;

	assign full    = (cnt_q == (AW+1)'(Depth));
	assign q_valid = (cnt_q != '0);
	assign useful  = byte_valid | message_end;   // empty beats are dropped here
	assign push_ok = useful & ~full;
	assign pop_ok  = q_take & q_valid;
	assign q_beat  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wp_q] <= '{data: data_byte, has_byte: byte_valid, is_end: message_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (pop_ok)  rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/shbs_core.sv =====
`default_nettype none
module shbs_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [31:0] w_blk [16],
	input  wire logic [31:0] h_in [8],
	output logic             busy,
	output logic             done,
	output logic [31:0]      h_out [8]
);
	import shbs_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [5:0]  rnd_q;
	logic        busy_q, done_q;
	logic [31:0] wi, wnew, g0, g1, s1, ch, t1, s0, mj;

	always_comb begin
		g0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		g1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + g0 + w_q[9] + g1;
		wi   = (rnd_q < 6'd16) ? w_q[0] : wnew;
		s1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + s1 + ch + K_TAB[rnd_q] + wi;
		s0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	always_ff @(posedge clk) begin
		if (go && !busy_q) begin
			w_q <= w_blk;
			v_q <= h_in;
		end else if (busy_q) begin
			// w_q is a rolling window: w_q[0] is the word for rounds 0-15; later rounds use wnew
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wi;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + s0 + mj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go && !busy_q) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == 6'(RoundCount-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) h_out[i] = h_in[i] + v_q[i];
	end
	assign busy = busy_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== hdl/shbs_back.sv =====
`default_nettype none
module shbs_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire shbs_pkg::beat_t q_beat,
	input  wire logic            q_valid,
	output logic                 q_take,
	output logic [31:0]          digest_word,
	output logic                 digest_last,
	output logic                 empty,
	input  wire logic            pop
);
	import shbs_pkg::*;

	localparam logic [2:0] ST_ABSORB = 3'd0;
	localparam logic [2:0] ST_RUN    = 3'd1;
	localparam logic [2:0] ST_PAD    = 3'd2;
	localparam logic [2:0] ST_RUNPAD = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0]  st_q;
	logic [31:0] blk_q [16];
	logic [31:0] h_q [8];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        last_pad_q;   // padding block under way is the final one
	logic        pad_due_q;    // block filled by data; pad byte still owed
	logic [2:0]  oidx_q;
	logic        go, core_busy, core_done;
	logic [31:0] h_new [8];
	logic        absorb;

	shbs_core u_core (
		.clk(clk), .arst_n(arst_n), .go(go), .w_blk(blk_q), .h_in(h_q),
		.busy(core_busy), .done(core_done), .h_out(h_new)
	);

	assign absorb = (st_q == ST_ABSORB) && q_valid;
	assign q_take = absorb;
	assign go = ((st_q == ST_RUN) || (st_q == ST_RUNPAD)) && !core_busy && !core_done;
	assign empty = (st_q != ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign digest_last = (oidx_q == 3'd7);

	always_ff @(posedge clk) begin
		logic [5:0] f;
		f = fill_q;
		if (absorb) begin
			if (q_beat.has_byte) begin
				blk_q[f[5:2]][(3 - f[1:0]) * 8 +: 8] <= q_beat.data;
				f = f + 1'b1;
			end
			if (q_beat.is_end && (!q_beat.has_byte || fill_q != 6'd63)) begin
				blk_q[f[5:2]][(3 - f[1:0]) * 8 +: 8] <= PadByte;
				// clear rest of the word holding the pad byte
				for (int b = 0; b < 3; b++)
					if (b < 3 - f[1:0]) blk_q[f[5:2]][b*8 +: 8] <= 8'h00;
			end
		end else if (st_q == ST_PAD) begin
			// pad block: zero words after fill, pad byte in word 0 if still owed, length if it fits
			for (int i = 0; i < 16; i++) begin
				if (last_pad_q && i == 14) blk_q[i] <= bits_q[63:32];
				else if (last_pad_q && i == 15) blk_q[i] <= bits_q[31:0];
				else if (pad_due_q && i == 0) blk_q[i] <= {PadByte, 24'h0};
				else if (i >= fill_q[5:2] + ((fill_q[1:0] != 2'd0) ? 1 : 0))
					blk_q[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_ABSORB;
			fill_q     <= '0;
			bits_q     <= '0;
			last_pad_q <= 1'b0;
			pad_due_q  <= 1'b0;
			oidx_q     <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
		end else begin
			unique case (st_q)
				ST_ABSORB: if (absorb) begin
					logic [6:0] n;
					n = {1'b0, fill_q} + 7'(q_beat.has_byte);
					bits_q <= bits_q + (q_beat.has_byte ? 64'd8 : 64'd0);
					if (q_beat.is_end) begin
						last_pad_q <= (n + 7'd1) <= 7'(LenOffset);
						pad_due_q <= n[6];
						if (n >= 7'd63) begin
							// block is full; length (and pad byte if still owed) go to a fresh block
							fill_q <= '0; st_q <= ST_RUNPAD;
						end else begin
							fill_q <= n[5:0] + 1'b1;
							st_q <= ST_PAD;
						end
					end else if (n == 7'd64) begin
						fill_q <= '0; st_q <= ST_RUN;
					end else begin
						fill_q <= n[5:0];
					end
				end
				ST_RUN: if (core_done) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_new[i];
					st_q <= ST_ABSORB;
				end
				ST_PAD: st_q <= ST_RUNPAD;
				ST_RUNPAD: if (core_done) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_new[i];
					if (last_pad_q) begin
						st_q <= ST_OUT; oidx_q <= '0;
					end else begin
						// second pad block: pad byte only if not yet placed
						last_pad_q <= 1'b1;
						fill_q <= '0;
						st_q <= ST_PAD;
					end
				end
				ST_OUT: if (pop) begin
					oidx_q <= oidx_q + 1'b1;
					if (oidx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
						bits_q <= '0; fill_q <= '0; st_q <= ST_ABSORB;
					end
				end
				default: st_q <= ST_ABSORB;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher.sv =====
`default_nettype none
// channel | dir | handshake        | payload
// input   | in  | push / full      | data_byte, byte_valid, message_end
// result  | out | empty / pop      | digest_word, digest_last
// Bytes are absorbed one a cycle into a queue while it is not full; a full
// block stalls the back end for the 64 compression rounds (one round per
// cycle in the shared round unit). Message end adds one or two padding
// blocks, then eight digest beats. Reset (arst_n, async) loads the initial
// hash; no clearing pass. full rises when the front queue fills while the
// back end compresses, pads or waits for the digest beats to be popped.
module sha256_byte_stream_hasher #(
	parameter int FifoDepth = shbs_pkg::FifoDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        message_end,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      digest_word,
	output logic             digest_last
);
	import shbs_pkg::*;

	beat_t q_beat;
	logic  q_valid, q_take, f_full;

	shbs_front #(.Depth(FifoDepth)) u_front (
		.clk(clk), .arst_n(arst_n),
		.data_byte(data_byte), .byte_valid(byte_valid & push),
		.message_end(message_end & push), .full(f_full),
		.q_beat(q_beat), .q_valid(q_valid), .q_take(q_take)
	);

	assign full = f_full;

	shbs_back u_back (
		.clk(clk), .arst_n(arst_n), .q_beat(q_beat), .q_valid(q_valid),
		.q_take(q_take), .digest_word(digest_word), .digest_last(digest_last),
		.empty(empty), .pop(pop)
	);
endmodule
`default_nettype wire
